/* src/timestamp_difference_hms_assert.svh */
`ifndef TIMESTAMP_DIFFERENCE_HMS_ASSERT_SVH
`define TIMESTAMP_DIFFERENCE_HMS_ASSERT_SVH

// concurrent check, held off while reset is asserted
`define TDH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// concurrent check that stays live through reset
`define TDH_ASSERT_RESET(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* src/tdh_pkg.sv */
`timescale 1ns / 1ps

package tdh_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int HOURS_W = 27;

    // year range
    localparam int MAX_YEAR = 9999;
    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(MAX_YEAR);

    // internal widths
    localparam int DAYS_W      = 23;            // day count since 1 january of year 1
    localparam int DAYS_DIFF_W = DAYS_W + 1;    // signed day difference
    localparam int MS_W        = 12;            // minute*60 + second, up to 3843
    localparam int DBM_W       = 9;             // days before a month, up to 334
    localparam int ACC_W       = 30;            // signed hour count
    localparam int REM_W       = 12;            // seconds within an hour

    // time constants
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_MIN   = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int DAYS_PER_YEAR = 365;
    localparam int DIV25         = 25;

    // divide by 25 as multiply by reciprocal, exact for 12-bit operands
    localparam int Q_W           = YEAR_W - 2;
    localparam logic [Q_W-1:0] RECIP25 = Q_W'(2622);
    localparam int RECIP25_SHIFT = 16;
    localparam int PROD25_W      = 2 * Q_W;
    localparam int Q25_W         = PROD25_W - RECIP25_SHIFT;

    // divide by 60 as multiply by reciprocal, exact below 3600
    localparam int RECIP60_W     = 13;
    localparam logic [RECIP60_W-1:0] RECIP60 = RECIP60_W'(4370);
    localparam int RECIP60_SHIFT = 18;
    localparam int PROD60_W      = REM_W + RECIP60_W;

    localparam logic [HOURS_W-1:0] HOURS_MAX = '1;

    // month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    // cumulative days before each month of a common year
    localparam logic [DBM_W-1:0] DAYS_BEFORE [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // pipeline stage load enables
    typedef struct packed {
        logic load;
        logic days;
        logic diff;
        logic hours;
        logic scale;
        logic out;
    } stage_en_t;

    localparam int NUM_STAGES = 6;

endpackage

/* src/tdh_days.sv */
`timescale 1ns / 1ps

module tdh_days
    import tdh_pkg::*;
(
    input  logic                aclk,
    input  stage_en_t           en,
    input  logic [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]  month,
    input  logic [DAY_W-1:0]    day,
    input  logic [HOUR_W-1:0]   hour,
    input  logic [MIN_W-1:0]    minute,
    input  logic [SEC_W-1:0]    second,
    output logic [DAYS_W-1:0]   days,
    output logic [HOUR_W-1:0]   hour_out,
    output logic [MS_W-1:0]     min_sec,
    output logic                bad_month
);

    logic [YEAR_W-1:0]   year_clamped;
    logic [YEAR_W-1:0]   p_next, p_reg;
    logic [Q_W-1:0]      p4, p16;
    logic [Q_W-1:0]      y4_next, y4_reg;
    logic [Q_W-1:0]      y16_next, y16_reg;
    logic [3:0]          ylow_reg;
    logic [PROD25_W-1:0] pr100_next, pr100_reg;
    logic [PROD25_W-1:0] pr400_next, pr400_reg;
    logic [PROD25_W-1:0] pry4_next, pry4_reg;
    logic [PROD25_W-1:0] pry16_next, pry16_reg;
    logic [MONTH_W-1:0]  month_idx;
    logic [DBM_W-1:0]    dbm_next, dbm_reg;
    logic                after_feb_reg;
    logic                bad_next, bad1_reg, bad2_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [HOUR_W-1:0]   hour1_reg, hour2_reg;
    logic [MS_W-1:0]     ms_next, ms1_reg, ms2_reg;
    logic [Q25_W-1:0]    q100, q400, qy4, qy16;
    logic                div4, div100, div400, leap_add;
    logic [DAYS_W-1:0]   days_next, days_reg;

    // clamp year into range
    always_comb begin
        priority if (year == '0) begin
            year_clamped = YEAR_W'(1);
        end else if (year > YEAR_MAX) begin
            year_clamped = YEAR_MAX;
        end else begin
            year_clamped = year;
        end
    end

    // stage 1: reciprocal products for the century terms and leap test
    assign p_next     = year_clamped - YEAR_W'(1);
    assign p4         = p_next[YEAR_W-1:2];
    assign p16        = Q_W'(p_next[YEAR_W-1:4]);
    assign y4_next    = year_clamped[YEAR_W-1:2];
    assign y16_next   = Q_W'(year_clamped[YEAR_W-1:4]);
    assign pr100_next = PROD25_W'(p4) * PROD25_W'(RECIP25);
    assign pr400_next = PROD25_W'(p16) * PROD25_W'(RECIP25);
    assign pry4_next  = PROD25_W'(y4_next) * PROD25_W'(RECIP25);
    assign pry16_next = PROD25_W'(y16_next) * PROD25_W'(RECIP25);

    // month table lookup
    assign bad_next  = (month < MONTH_JAN) || (month > MONTH_DEC);
    assign month_idx = month - MONTH_JAN;
    assign dbm_next  = bad_next ? '0 : DAYS_BEFORE[month_idx];

    // seconds within the hour
    assign ms_next = MS_W'(minute) * MS_W'(SEC_PER_MIN) + MS_W'(second);

    always_ff @(posedge aclk) begin
        if (en.load) begin
            p_reg         <= p_next;
            y4_reg        <= y4_next;
            y16_reg       <= y16_next;
            ylow_reg      <= year_clamped[3:0];
            pr100_reg     <= pr100_next;
            pr400_reg     <= pr400_next;
            pry4_reg      <= pry4_next;
            pry16_reg     <= pry16_next;
            dbm_reg       <= dbm_next;
            after_feb_reg <= month > MONTH_FEB;
            bad1_reg      <= bad_next;
            day_reg       <= day;
            hour1_reg     <= hour;
            ms1_reg       <= ms_next;
        end
    end

    // stage 2: quotients, leap rule and day count
    assign q100 = pr100_reg[PROD25_W-1:RECIP25_SHIFT];
    assign q400 = pr400_reg[PROD25_W-1:RECIP25_SHIFT];
    assign qy4  = pry4_reg[PROD25_W-1:RECIP25_SHIFT];
    assign qy16 = pry16_reg[PROD25_W-1:RECIP25_SHIFT];

    assign div4     = (ylow_reg[1:0] == 2'b00);
    assign div100   = div4 && (y4_reg == Q_W'(qy4) * Q_W'(DIV25));
    assign div400   = (ylow_reg == 4'b0000) && (y16_reg == Q_W'(qy16) * Q_W'(DIV25));
    assign leap_add = ((div4 && !div100) || div400) && after_feb_reg;

    assign days_next = DAYS_W'(p_reg) * DAYS_W'(DAYS_PER_YEAR)
                     + DAYS_W'(p_reg[YEAR_W-1:2])
                     - DAYS_W'(q100)
                     + DAYS_W'(q400)
                     + DAYS_W'(dbm_reg)
                     + {{(DAYS_W-1){1'b0}}, leap_add}
                     + DAYS_W'(day_reg);

    always_ff @(posedge aclk) begin
        if (en.days) begin
            days_reg  <= days_next;
            hour2_reg <= hour1_reg;
            ms2_reg   <= ms1_reg;
            bad2_reg  <= bad1_reg;
        end
    end

    assign days      = days_reg;
    assign hour_out  = hour2_reg;
    assign min_sec   = ms2_reg;
    assign bad_month = bad2_reg;

endmodule

/* src/tdh_norm.sv */
`timescale 1ns / 1ps

module tdh_norm
    import tdh_pkg::*;
(
    input  logic                aclk,
    input  stage_en_t           en,
    input  logic [DAYS_W-1:0]   days_a,
    input  logic [DAYS_W-1:0]   days_b,
    input  logic [HOUR_W-1:0]   hour_a,
    input  logic [HOUR_W-1:0]   hour_b,
    input  logic [MS_W-1:0]     ms_a,
    input  logic [MS_W-1:0]     ms_b,
    input  logic                bad_a,
    input  logic                bad_b,
    output logic [HOURS_W-1:0]  hours,
    output logic [REM_W-1:0]    rem,
    output logic                bad
);

    localparam int DU_W  = MS_W + 1;
    localparam int DH_W  = HOUR_W + 1;
    localparam int DHK_W = HOUR_W + 2;
    localparam logic signed [DU_W-1:0] DU_HOUR = DU_W'(SEC_PER_HOUR);

    logic signed [DAYS_DIFF_W-1:0] dd_next, dd_reg;
    logic signed [DH_W-1:0]        dh;
    logic signed [DU_W-1:0]        du;
    logic signed [2:0]             carry;
    logic signed [DHK_W-1:0]       dhk_next, dhk_reg;
    logic [REM_W-1:0]              r_next, r_reg;
    logic                          bad3_reg, bad4_reg;
    logic signed [ACC_W-1:0]       acc;
    logic [ACC_W-1:0]              mag;
    logic [REM_W-1:0]              rem_next, rem_reg;
    logic [HOURS_W-1:0]            hours_next, hours_reg;

    // stage 3: signed differences of days, hours and seconds-in-hour
    assign dd_next = $signed({1'b0, days_b}) - $signed({1'b0, days_a});
    assign dh      = $signed({1'b0, hour_b}) - $signed({1'b0, hour_a});
    assign du      = $signed({1'b0, ms_b}) - $signed({1'b0, ms_a});

    // fold the seconds difference into 0..3599 with an hour carry
    always_comb begin
        priority if (du >= DU_HOUR) begin
            carry  = 3'sd1;
            r_next = REM_W'(du - DU_HOUR);
        end else if (du >= 0) begin
            carry  = 3'sd0;
            r_next = REM_W'(du);
        end else if (du >= -DU_HOUR) begin
            carry  = -3'sd1;
            r_next = REM_W'(du + DU_HOUR);
        end else begin
            carry  = -3'sd2;
            r_next = REM_W'(du + DU_HOUR + DU_HOUR);
        end
    end

    assign dhk_next = DHK_W'(dh) + DHK_W'(carry);

    always_ff @(posedge aclk) begin
        if (en.diff) begin
            dd_reg   <= dd_next;
            dhk_reg  <= dhk_next;
            r_reg    <= r_next;
            bad3_reg <= bad_a || bad_b;
        end
    end

    // stage 4: total signed hours, then magnitude with remainder borrow
    assign acc = ACC_W'(dd_reg) * ACC_W'(HOURS_PER_DAY) + ACC_W'(dhk_reg);

    always_comb begin
        priority if (!acc[ACC_W-1]) begin
            mag      = acc;
            rem_next = r_reg;
        end else if (r_reg == '0) begin
            mag      = -acc;
            rem_next = '0;
        end else begin
            mag      = ~acc;
            rem_next = REM_W'(SEC_PER_HOUR) - r_reg;
        end
    end

    // saturate to the hours field
    assign hours_next = (mag > ACC_W'(HOURS_MAX)) ? HOURS_MAX : mag[HOURS_W-1:0];

    always_ff @(posedge aclk) begin
        if (en.hours) begin
            hours_reg <= hours_next;
            rem_reg   <= rem_next;
            bad4_reg  <= bad3_reg;
        end
    end

    assign hours = hours_reg;
    assign rem   = rem_reg;
    assign bad   = bad4_reg;

endmodule

/* src/tdh_split.sv */
`timescale 1ns / 1ps

module tdh_split
    import tdh_pkg::*;
(
    input  logic                aclk,
    input  stage_en_t           en,
    input  logic [HOURS_W-1:0]  hours,
    input  logic [REM_W-1:0]    rem,
    input  logic                bad,
    output logic [HOURS_W-1:0]  diff_hours,
    output logic [MIN_W-1:0]    diff_minutes,
    output logic [SEC_W-1:0]    diff_seconds,
    output logic                bad_input
);

    logic [PROD60_W-1:0] prod_next, prod_reg;
    logic [REM_W-1:0]    rem5_reg;
    logic [HOURS_W-1:0]  hours5_reg;
    logic                bad5_reg;
    logic [MIN_W-1:0]    mins;
    logic [REM_W-1:0]    secs_full;
    logic [HOURS_W-1:0]  hours_out_reg;
    logic [MIN_W-1:0]    mins_out_reg;
    logic [SEC_W-1:0]    secs_out_reg;
    logic                bad_out_reg;

    // stage 5: reciprocal product for minutes
    assign prod_next = PROD60_W'(rem) * PROD60_W'(RECIP60);

    always_ff @(posedge aclk) begin
        if (en.scale) begin
            prod_reg   <= prod_next;
            rem5_reg   <= rem;
            hours5_reg <= hours;
            bad5_reg   <= bad;
        end
    end

    // stage 6: minutes and leftover seconds into the output register
    assign mins      = MIN_W'(prod_reg[PROD60_W-1:RECIP60_SHIFT]);
    assign secs_full = rem5_reg - REM_W'(mins) * REM_W'(SEC_PER_MIN);

    always_ff @(posedge aclk) begin
        if (en.out) begin
            hours_out_reg <= bad5_reg ? '0 : hours5_reg;
            mins_out_reg  <= bad5_reg ? '0 : mins;
            secs_out_reg  <= bad5_reg ? '0 : SEC_W'(secs_full);
            bad_out_reg   <= bad5_reg;
        end
    end

    assign diff_hours   = hours_out_reg;
    assign diff_minutes = mins_out_reg;
    assign diff_seconds = secs_out_reg;
    assign bad_input    = bad_out_reg;

endmodule

/* src/timestamp_difference_hms.sv */
`timescale 1ns / 1ps
// Absolute difference of two Gregorian date-and-time stamps, as hours, minutes, seconds.
// Input channel s_*: one beat carries both timestamps; the result channel m_* returns
// exactly one beat per input beat, in order, with bad_input set (and the other fields
// zero) when either month is outside 1 to 12. Years are clamped to 1..9999.
// Six register stages: century quotients, day counts, differences, signed hours and
// magnitude, minute split, output register.
// Throughput is one beat per cycle while m_ready is high; every stage has its own
// valid bit and loads whenever it is empty or the stage after it moves on, so bubbles
// are squeezed out and new beats are still taken while a result waits on m_ready.
// With m_ready held low the six stages fill and s_ready then drops; nothing is lost
// or repeated. aresetn (synchronous, active low) clears all valid bits; the datapath
// registers are not reset.
module timestamp_difference_hms
    import tdh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [YEAR_W-1:0]   s_first_year,
    input  logic [MONTH_W-1:0]  s_first_month,
    input  logic [DAY_W-1:0]    s_first_day,
    input  logic [HOUR_W-1:0]   s_first_hour,
    input  logic [MIN_W-1:0]    s_first_minute,
    input  logic [SEC_W-1:0]    s_first_second,
    input  logic [YEAR_W-1:0]   s_second_year,
    input  logic [MONTH_W-1:0]  s_second_month,
    input  logic [DAY_W-1:0]    s_second_day,
    input  logic [HOUR_W-1:0]   s_second_hour,
    input  logic [MIN_W-1:0]    s_second_minute,
    input  logic [SEC_W-1:0]    s_second_sec,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [HOURS_W-1:0]  m_diff_hours,
    output logic [MIN_W-1:0]    m_diff_minutes,
    output logic [SEC_W-1:0]    m_diff_seconds,
    output logic                m_bad_input
);

    stage_en_t              stage_en;
    logic [NUM_STAGES-1:0]  valid_next, valid_reg;

    logic [DAYS_W-1:0]      days_a, days_b;
    logic [HOUR_W-1:0]      hour_a, hour_b;
    logic [MS_W-1:0]        ms_a, ms_b;
    logic                   bad_a, bad_b;
    logic [HOURS_W-1:0]     hours;
    logic [REM_W-1:0]       rem;
    logic                   bad;

    // a stage loads when empty or when its successor loads
    always_comb begin
        stage_en.out   = !valid_reg[5] || m_ready;
        stage_en.scale = !valid_reg[4] || stage_en.out;
        stage_en.hours = !valid_reg[3] || stage_en.scale;
        stage_en.diff  = !valid_reg[2] || stage_en.hours;
        stage_en.days  = !valid_reg[1] || stage_en.diff;
        stage_en.load  = !valid_reg[0] || stage_en.days;
    end

    // valid bits travel with the beat
    always_comb begin
        valid_next[0] = stage_en.load  ? s_valid      : valid_reg[0];
        valid_next[1] = stage_en.days  ? valid_reg[0] : valid_reg[1];
        valid_next[2] = stage_en.diff  ? valid_reg[1] : valid_reg[2];
        valid_next[3] = stage_en.hours ? valid_reg[2] : valid_reg[3];
        valid_next[4] = stage_en.scale ? valid_reg[3] : valid_reg[4];
        valid_next[5] = stage_en.out   ? valid_reg[4] : valid_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en.load;
    assign m_valid = valid_reg[5];

    // day counts of both timestamps
    tdh_days u_days_first (
        .aclk      (aclk),
        .en        (stage_en),
        .year      (s_first_year),
        .month     (s_first_month),
        .day       (s_first_day),
        .hour      (s_first_hour),
        .minute    (s_first_minute),
        .second    (s_first_second),
        .days      (days_a),
        .hour_out  (hour_a),
        .min_sec   (ms_a),
        .bad_month (bad_a)
    );

    tdh_days u_days_second (
        .aclk      (aclk),
        .en        (stage_en),
        .year      (s_second_year),
        .month     (s_second_month),
        .day       (s_second_day),
        .hour      (s_second_hour),
        .minute    (s_second_minute),
        .second    (s_second_sec),
        .days      (days_b),
        .hour_out  (hour_b),
        .min_sec   (ms_b),
        .bad_month (bad_b)
    );

    // difference as absolute hours plus seconds within the hour
    tdh_norm u_norm (
        .aclk   (aclk),
        .en     (stage_en),
        .days_a (days_a),
        .days_b (days_b),
        .hour_a (hour_a),
        .hour_b (hour_b),
        .ms_a   (ms_a),
        .ms_b   (ms_b),
        .bad_a  (bad_a),
        .bad_b  (bad_b),
        .hours  (hours),
        .rem    (rem),
        .bad    (bad)
    );

    // minutes and seconds, output register
    tdh_split u_split (
        .aclk         (aclk),
        .en           (stage_en),
        .hours        (hours),
        .rem          (rem),
        .bad          (bad),
        .diff_hours   (m_diff_hours),
        .diff_minutes (m_diff_minutes),
        .diff_seconds (m_diff_seconds),
        .bad_input    (m_bad_input)
    );

endmodule

/* src/tdh_checker.sv */
`timescale 1ns / 1ps
`include "timestamp_difference_hms_assert.svh"

module tdh_checker
    import tdh_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [HOURS_W-1:0]  m_diff_hours,
    input logic [MIN_W-1:0]    m_diff_minutes,
    input logic [SEC_W-1:0]    m_diff_seconds,
    input logic                m_bad_input
);

    // a stalled result beat holds
    `TDH_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_diff_hours) && $stable(m_diff_minutes) && $stable(m_diff_seconds) && $stable(m_bad_input), "result beat changed while stalled")

    // with the output free to move the pipe must be ready for a beat
    `TDH_ASSERT(a_ready_when_free, !m_valid || m_ready |-> s_ready, "input stalled with output stage free")

    // bad month gives an all-zero difference
    `TDH_ASSERT(a_bad_zero, m_valid && m_bad_input |-> m_diff_hours == '0 && m_diff_minutes == '0 && m_diff_seconds == '0, "non-zero fields on bad month")

    // minutes and seconds are within range
    `TDH_ASSERT(a_ms_range, m_valid |-> m_diff_minutes < MIN_W'(SEC_PER_MIN) && m_diff_seconds < SEC_W'(SEC_PER_MIN), "minutes or seconds out of range")

    // reset empties the output stage
    `TDH_ASSERT_RESET(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind timestamp_difference_hms tdh_checker u_tdh_checker (.*);
